/* hdl/gclfu_pkg.sv */
// Shared types and constants of the glyph cache replacement block.
package gclfu_pkg;

	localparam int SLOTS_DEF      = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CAP_W    = 8;
	localparam int GCOUNT_W = 6;
	localparam int SLOT_W   = 5;
	localparam int CODE_W   = 32;
	localparam int ENTRY_W  = 5;
	localparam int KIND_W   = 3;
	localparam int TOTAL_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CACHE_CAPACITY = 1'b0,
		REG_GLYPH_COUNT    = 1'b1
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_EVICT = 3'd0,
		KIND_HIT   = 3'd1,
		KIND_FILL  = 3'd2,
		KIND_NONE  = 3'd3,
		KIND_LOAD  = 3'd4
	} kind_t;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_REQUEST = 1'b1
	} mode_t;

	typedef struct packed {
		logic                mode;
		logic [SLOT_W-1:0]   slot;
		logic [CODE_W-1:0]   char_code;
	} in_word_t;

	typedef struct packed {
		kind_t               kind;
		logic [ENTRY_W-1:0]  entry;
		logic                last;
	} out_word_t;

	typedef struct packed {
		logic take;
		logic do_load;
		logic rep_sel;
		logic look_start;
		logic look_step;
		logic found;
		logic bump_wr;
		logic min_start;
		logic min_step;
		logic emit_none;
		logic emit_hit;
		logic evict;
		logic fill;
	} gclfu_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_repeat;
		logic used_zero;
		logic look_hit;
		logic look_last;
		logic tgt_cached;
		logic need_evict;
		logic min_done;
		logic out_free;
	} gclfu_stat_t;

endpackage

/* hdl/gclfu_chan_if.sv */
// Valid/ready channel carrying one word per handshake.
interface gclfu_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/glyph_cache_lfu_policy.sv */
// Glyph cache replacement policy, least frequently used, top level.
//
// Channels: req carries one word per item (mode, slot, char_code); rsp carries
// result words (kind, entry, last), last marking the final word of an item.
// Configuration: a write with cfg_we high stores cfg_data into register
// cfg_idx (0 cache_capacity, 1 glyph_count); write only while the block idles.
// One item is worked on at a time; req.ready drops from acceptance until the
// item's last result word is placed in the output register.
// A lookup scans the glyph table slots in order, and each eviction scans all
// SLOTS use counts for the least used cached slot. The scan pace is one slot
// a cycle, set by the single read port of the glyph table and of the use
// count memory.
// Reset: counts, cached flags and history clear at once through per-slot
// valid bits; capacity returns to 100, glyph_count to 0. No clearing pass.
// A stalled receiver holds the result word in the output register and
// freezes the sequencer; the next item may be accepted while the last word
// of the previous one still waits.
module glyph_cache_lfu_policy #(
	parameter int SLOTS      = gclfu_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = gclfu_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gclfu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [gclfu_pkg::CFG_DATA_W-1:0]  cfg_data,
	gclfu_chan_if.sink                        req,
	gclfu_chan_if.source                      rsp
);
	import gclfu_pkg::*;

	gclfu_cmd_t  cmd;
	gclfu_stat_t st;
	logic        in_ready;

	assign req.ready = in_ready;

	gclfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	gclfu_dp #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (req.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

/* hdl/gclfu_ctrl.sv */
// Sequencer for load, lookup, count update, eviction scan and result words.
module gclfu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gclfu_pkg::gclfu_stat_t st,
	output gclfu_pkg::gclfu_cmd_t  cmd
);
	import gclfu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOOK,
		S_BUMP_RD,
		S_BUMP_WR,
		S_EVICT_CHK,
		S_MIN_SCAN,
		S_EMIT_LOAD,
		S_EMIT_NONE,
		S_EMIT_HIT,
		S_EMIT_EVICT,
		S_EMIT_FILL
	} state_t;

	state_t state_q;
	logic   rdy_q;
	logic   rep_q;

	assign in_ready = rdy_q;

	always_comb begin
		cmd            = '0;
		cmd.take       = rdy_q && in_valid;
		unique case (state_q)
			S_DISPATCH: begin
				cmd.rep_sel    = !st.is_load && st.is_repeat;
				cmd.look_start = !st.is_load && !st.is_repeat;
			end
			S_LOOK: begin
				cmd.look_step = 1'b1;
				cmd.found     = st.look_hit;
			end
			S_BUMP_WR:    cmd.bump_wr   = 1'b1;
			S_EVICT_CHK:  cmd.min_start = st.need_evict;
			S_MIN_SCAN:   cmd.min_step  = 1'b1;
			S_EMIT_LOAD:  cmd.do_load   = st.out_free;
			S_EMIT_NONE:  cmd.emit_none = st.out_free;
			S_EMIT_HIT:   cmd.emit_hit  = st.out_free;
			S_EMIT_EVICT: cmd.evict     = st.out_free;
			S_EMIT_FILL:  cmd.fill      = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
			rep_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rdy_q && in_valid) begin
						rdy_q   <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					priority if (st.is_load) begin
						state_q <= S_EMIT_LOAD;
					end else if (st.is_repeat) begin
						rep_q   <= 1'b1;
						state_q <= S_BUMP_RD;
					end else begin
						rep_q   <= 1'b0;
						state_q <= st.used_zero ? S_EMIT_NONE : S_LOOK;
					end
				end
				S_LOOK: begin
					priority if (st.look_hit) begin
						state_q <= S_BUMP_RD;
					end else if (st.look_last) begin
						state_q <= S_EMIT_NONE;
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_BUMP_RD: state_q <= S_BUMP_WR;
				S_BUMP_WR: begin
					state_q <= (rep_q || st.tgt_cached) ? S_EMIT_HIT : S_EVICT_CHK;
				end
				S_EVICT_CHK: begin
					state_q <= st.need_evict ? S_MIN_SCAN : S_EMIT_FILL;
				end
				S_MIN_SCAN: begin
					if (st.min_done) begin
						state_q <= S_EMIT_EVICT;
					end
				end
				S_EMIT_EVICT: begin
					if (st.out_free) begin
						state_q <= S_EVICT_CHK;
					end
				end
				S_EMIT_LOAD, S_EMIT_NONE, S_EMIT_HIT, S_EMIT_FILL: begin
					if (st.out_free) begin
						rdy_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					rdy_q   <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/gclfu_dp.sv */
// Glyph table, use counts, cached flags, scan pipelines and result register.
module gclfu_dp #(
	parameter int SLOTS      = gclfu_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = gclfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gclfu_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gclfu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  gclfu_pkg::in_word_t                  in_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output gclfu_pkg::out_word_t                 out_data,
	input  gclfu_pkg::gclfu_cmd_t                cmd,
	output gclfu_pkg::gclfu_stat_t               st
);
	import gclfu_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int USED_W = 7;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
	localparam logic [USED_W-1:0] SLOTS_U   = USED_W'(SLOTS);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [CAP_W-1:0]    cap_q;
	logic [GCOUNT_W-1:0] gcount_q;

	logic                mode_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CODE_W-1:0]   code_q;

	logic [CODE_W-1:0]   prev_char_q;
	logic [IDX_W-1:0]    prev_slot_q;
	logic                prev_found_q;
	logic [IDX_W-1:0]    tgt_q;

	logic [SLOTS-1:0]    cached_q;
	logic [SLOTS-1:0]    cnt_vld_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [CODE_W-1:0]     glyph_mem [SLOTS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOTS];

	logic [IDX_W-1:0]    look_idx_q;
	logic                look_vld_s1;
	logic [IDX_W-1:0]    look_idx_s1;
	logic [CODE_W-1:0]   gdata_s1;

	logic [IDX_W-1:0]    min_idx_q;
	logic                min_vld_s1;
	logic [IDX_W-1:0]    min_idx_s1;
	logic                any_q;
	logic [COUNT_BITS-1:0] best_q;
	logic [IDX_W-1:0]    victim_q;

	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic                  cnt_rv_s1;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [IDX_W-1:0]      cnt_raddr;

	logic                out_vld_q;
	out_word_t           out_q;

	logic [USED_W-1:0]   used;
	logic [CAP_W-1:0]    cap_eff;
	logic                ld_ok;
	logic [IDX_W-1:0]    ld_addr;
	logic                min_take;

	assign used    = (USED_W'(gcount_q) > SLOTS_U) ? SLOTS_U : USED_W'(gcount_q);
	assign cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign ld_ok   = USED_W'(slot_q) < SLOTS_U;
	assign ld_addr = IDX_W'(slot_q);
	assign cnt_raddr = cmd.min_step ? min_idx_q : tgt_q;
	assign cnt_eff = cnt_rv_s1 ? cnt_rd_s1 : '0;
	assign min_take = cmd.min_step && min_vld_s1 && cached_q[min_idx_s1] &&
		(!any_q || cnt_eff < best_q);

	assign st.is_load    = (mode_q == MODE_LOAD);
	assign st.is_repeat  = prev_found_q && (code_q == prev_char_q);
	assign st.used_zero  = (used == '0);
	assign st.look_hit   = look_vld_s1 && (gdata_s1 == code_q);
	assign st.look_last  = look_vld_s1 && ((USED_W'(look_idx_s1) + USED_W'(1)) == used);
	assign st.tgt_cached = cached_q[tgt_q];
	assign st.need_evict = (CAP_W'(total_q) >= cap_eff) && (|cached_q);
	assign st.min_done   = min_vld_s1 && (min_idx_s1 == LAST_IDX);
	assign st.out_free   = !out_vld_q || out_ready;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// memories: glyph codes and use counts
	always_ff @(posedge clk) begin
		if (cmd.do_load && ld_ok) begin
			glyph_mem[ld_addr] <= code_q;
		end
		gdata_s1 <= glyph_mem[look_idx_q];
		if (cmd.bump_wr) begin
			cnt_mem[tgt_q] <= (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + COUNT_BITS'(1);
		end
		cnt_rd_s1 <= cnt_mem[cnt_raddr];
	end

	// item and scan payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= in_data.mode;
			slot_q <= in_data.slot;
			code_q <= in_data.char_code;
		end
		look_idx_s1 <= look_idx_q;
		min_idx_s1  <= min_idx_q;
		if (min_take) begin
			best_q   <= cnt_eff;
			victim_q <= min_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			gcount_q     <= '0;
			prev_char_q  <= '0;
			prev_slot_q  <= '0;
			prev_found_q <= 1'b0;
			tgt_q        <= '0;
			cached_q     <= '0;
			cnt_vld_q    <= '0;
			total_q      <= '0;
			look_idx_q   <= '0;
			look_vld_s1  <= 1'b0;
			min_idx_q    <= '0;
			min_vld_s1   <= 1'b0;
			any_q        <= 1'b0;
			cnt_rv_s1    <= 1'b0;
		end else begin
			cnt_rv_s1 <= cnt_vld_q[cnt_raddr];

			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_CACHE_CAPACITY: cap_q <= cfg_data;
					REG_GLYPH_COUNT: begin
						gcount_q     <= cfg_data[GCOUNT_W-1:0];
						prev_found_q <= 1'b0;
					end
					default: ;
				endcase
			end

			if (cmd.do_load) begin
				prev_found_q <= 1'b0;
				if (ld_ok) begin
					cnt_vld_q[ld_addr] <= 1'b0;
					cached_q[ld_addr]  <= 1'b0;
					if (cached_q[ld_addr] && total_q != '0) begin
						total_q <= total_q - TOTAL_W'(1);
					end
				end
			end

			if (cmd.rep_sel) begin
				tgt_q <= prev_slot_q;
			end

			if (cmd.look_start) begin
				prev_char_q  <= code_q;
				prev_found_q <= 1'b0;
				look_idx_q   <= '0;
				look_vld_s1  <= 1'b0;
			end else if (cmd.look_step) begin
				look_vld_s1 <= 1'b1;
				if (look_idx_q != LAST_IDX) begin
					look_idx_q <= look_idx_q + IDX_W'(1);
				end
			end

			if (cmd.found) begin
				prev_found_q <= 1'b1;
				prev_slot_q  <= look_idx_s1;
				tgt_q        <= look_idx_s1;
			end

			if (cmd.bump_wr) begin
				cnt_vld_q[tgt_q] <= 1'b1;
			end

			if (cmd.min_start) begin
				min_idx_q  <= '0;
				min_vld_s1 <= 1'b0;
				any_q      <= 1'b0;
			end else if (cmd.min_step) begin
				min_vld_s1 <= 1'b1;
				if (min_idx_q != LAST_IDX) begin
					min_idx_q <= min_idx_q + IDX_W'(1);
				end
				if (min_take) begin
					any_q <= 1'b1;
				end
			end

			if (cmd.evict) begin
				cached_q[victim_q] <= 1'b0;
				total_q            <= total_q - TOTAL_W'(1);
			end

			if (cmd.fill) begin
				cached_q[tgt_q] <= 1'b1;
				total_q         <= total_q + TOTAL_W'(1);
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.do_load || cmd.emit_none || cmd.emit_hit || cmd.evict || cmd.fill) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.do_load) begin
			out_q <= '{kind: KIND_LOAD, entry: slot_q, last: 1'b1};
		end else if (cmd.emit_none) begin
			out_q <= '{kind: KIND_NONE, entry: '0, last: 1'b1};
		end else if (cmd.emit_hit) begin
			out_q <= '{kind: KIND_HIT, entry: ENTRY_W'(tgt_q), last: 1'b1};
		end else if (cmd.evict) begin
			out_q <= '{kind: KIND_EVICT, entry: ENTRY_W'(victim_q), last: 1'b0};
		end else if (cmd.fill) begin
			out_q <= '{kind: KIND_FILL, entry: ENTRY_W'(tgt_q), last: 1'b1};
		end else begin
			out_q <= out_q;
		end
	end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the glyph cache LFU replacement policy block.
module tb;
	import gclfu_pkg::*;

	localparam int LIMIT     = 2_000_000;
	localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;

	class glyph_lfu_tracker;
		logic [CODE_W-1:0] code_tab [SLOTS_DEF];
		int unsigned       uses [SLOTS_DEF];
		bit                held [SLOTS_DEF];
		int unsigned       held_n;
		logic [CODE_W-1:0] prev_code;
		int unsigned       prev_slot;
		bit                prev_hit;
		int unsigned       capacity;
		int unsigned       table_len;
		out_word_t         expected_words [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       taken;
		int unsigned       burst_max;
		int unsigned       tally [5];

		function new();
			reset_state();
		endfunction

		function void reset_state();
			for (int i = 0; i < SLOTS_DEF; i++) begin
				code_tab[i] = '0;
				uses[i] = 0;
				held[i] = 1'b0;
			end
			held_n = 0;
			prev_code = '0;
			prev_slot = 0;
			prev_hit = 1'b0;
			capacity = 32'(CAP_RESET);
			table_len = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_CACHE_CAPACITY) begin
				capacity = 32'(v);
			end else begin
				table_len = 32'(v[GCOUNT_W-1:0]);
				prev_hit = 1'b0;
			end
		endfunction

		function void bump(int unsigned s);
			if (uses[s] < COUNT_MAX)
				uses[s]++;
		endfunction

		function void add(kind_t k, int unsigned e);
			out_word_t w;
			w.kind = k;
			w.entry = e[ENTRY_W-1:0];
			w.last = 1'b0;
			expected_words.push_back(w);
			tally[int'(k)]++;
		endfunction

		function void take_word(in_word_t w);
			out_word_t   tail;
			int unsigned used, cap, s, victim, n0;
			bit          found, seen;
			n0 = expected_words.size();
			taken++;
			if (w.mode == MODE_LOAD) begin
				code_tab[w.slot] = w.char_code;
				uses[w.slot] = 0;
				if (held[w.slot] && held_n > 0)
					held_n--;
				held[w.slot] = 1'b0;
				prev_hit = 1'b0;
				add(KIND_LOAD, 32'(w.slot));
			end else if (prev_hit && w.char_code == prev_code) begin
				bump(prev_slot);
				add(KIND_HIT, prev_slot);
			end else begin
				used = (table_len > SLOTS_DEF) ? SLOTS_DEF : table_len;
				cap = (capacity == 0) ? 1 : capacity;
				found = 1'b0;
				s = 0;
				for (int i = 0; i < used && !found; i++) begin
					if (code_tab[i] == w.char_code) begin
						found = 1'b1;
						s = i;
					end
				end
				prev_code = w.char_code;
				if (!found) begin
					prev_hit = 1'b0;
					add(KIND_NONE, 0);
				end else begin
					prev_hit = 1'b1;
					prev_slot = s;
					bump(s);
					if (held[s]) begin
						add(KIND_HIT, s);
					end else begin
						seen = 1'b1;
						while (held_n >= cap && seen) begin
							seen = 1'b0;
							victim = 0;
							for (int i = 0; i < SLOTS_DEF; i++) begin
								if (held[i] && (!seen || uses[i] < uses[victim])) begin
									seen = 1'b1;
									victim = i;
								end
							end
							if (seen) begin
								held[victim] = 1'b0;
								held_n--;
								add(KIND_EVICT, victim);
							end
						end
						held[s] = 1'b1;
						held_n = (held_n + 1) & 63;
						add(KIND_FILL, s);
					end
				end
			end
			tail = expected_words.pop_back();
			tail.last = 1'b1;
			expected_words.push_back(tail);
			if (expected_words.size() - n0 > burst_max)
				burst_max = expected_words.size() - n0;
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: kind %0d entry %0d last %0d",
						got.kind, got.entry, got.last);
				return;
			end
			want = expected_words.pop_front();
			if (got.kind !== want.kind || got.entry !== want.entry || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at word %0d: expected kind %0d entry %0d last %0d,",
						" got kind %0d entry %0d last %0d"},
						checked, want.kind, want.entry, want.last,
						got.kind, got.entry, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	gclfu_chan_if #(.data_t(in_word_t))  req_ch ();
	gclfu_chan_if #(.data_t(out_word_t)) rsp_ch ();

	glyph_cache_lfu_policy uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	glyph_lfu_tracker lfu = new();

	int unsigned       cycles = 0;
	int                send_idle = 35;
	int                recv_idle = 72;
	int unsigned       cur_gc = 0;
	in_word_t          send_q [$];
	logic [CODE_W-1:0] stim_tab [SLOTS_DEF];
	bit                stim_written [SLOTS_DEF];
	logic [CODE_W-1:0] stim_prev = '0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** glyph_cache_lfu_policy: FAILED **");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				lfu.check_word(rsp_ch.data);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic void queue_load(int unsigned slot, logic [CODE_W-1:0] code);
		in_word_t w;
		w.mode = MODE_LOAD;
		w.slot = slot[SLOT_W-1:0];
		w.char_code = code;
		send_q.push_back(w);
		stim_tab[slot] = code;
		stim_written[slot] = 1'b1;
	endfunction

	function automatic void queue_request(logic [CODE_W-1:0] code);
		in_word_t w;
		w.mode = MODE_REQUEST;
		w.slot = SLOT_W'($urandom_range(31));
		w.char_code = code;
		send_q.push_back(w);
		stim_prev = code;
	endfunction

	function automatic void queue_random(int n);
		int unsigned used, roll, pick;
		used = (cur_gc > SLOTS_DEF) ? SLOTS_DEF : cur_gc;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < 12) begin
				pick = $urandom_range(31);
				if ($urandom_range(4) == 0)
					queue_load(pick, stim_tab[$urandom_range(31)]);
				else
					queue_load(pick, $urandom());
			end else if (roll < 27) begin
				queue_request(stim_prev);
			end else if (roll < 37 || used == 0) begin
				queue_request($urandom());
			end else begin
				// skew toward low slots so use counts spread apart
				pick = $urandom_range($urandom_range(used - 1));
				queue_request(stim_tab[pick]);
			end
		end
	endfunction

	task automatic drive_words();
		while (send_q.size() != 0) begin
			if ($urandom_range(99) < send_idle) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				continue;
			end
			req_ch.valid <= 1'b1;
			req_ch.data <= send_q[0];
			@(posedge clk);
			while (!req_ch.ready)
				@(posedge clk);
			lfu.take_word(send_q.pop_front());
		end
		req_ch.valid <= 1'b0;
	endtask

	task automatic drain(int tail);
		int waited;
		waited = 0;
		while (lfu.expected_words.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (tail) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		lfu.write_reg(idx, v[CFG_DATA_W-1:0]);
		if (idx == REG_GLYPH_COUNT)
			cur_gc = 32'(v[GCOUNT_W-1:0]);
	endtask

	int unsigned cap_plan [6] = '{255, 1, 8, 0, 4, 200};
	int unsigned gc_plan [6]  = '{32, 63, 20, 32, 12, 31};
	int unsigned failures;

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_CACHE_CAPACITY;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			stim_tab[i] = '0;
			stim_written[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty font, then a small table with a duplicate code
		queue_request(32'h0000_0000);
		queue_request(32'hFFFF_FFFF);
		queue_load(0, 32'h0000_0000);
		queue_load(1, 32'hFFFF_FFFF);
		queue_load(2, 32'h5A5A_A5A5);
		queue_load(3, 32'hFFFF_FFFF);
		queue_load(31, 32'h8000_0001);
		drive_words();
		drain(8);

		set_reg(REG_CACHE_CAPACITY, 2);
		set_reg(REG_GLYPH_COUNT, 4);
		queue_request(32'hFFFF_FFFF);
		queue_request(32'hFFFF_FFFF);
		queue_request(32'h0000_0000);
		queue_request(32'h5A5A_A5A5);
		queue_request(32'h1234_5678);
		queue_request(32'h0000_0000);
		queue_request(32'h0000_0000);
		queue_load(0, 32'h0000_0000);
		queue_request(32'h0000_0000);
		queue_request(32'hFFFF_FFFF);
		drive_words();
		drain(8);

		set_reg(REG_GLYPH_COUNT, 4);
		set_reg(REG_CACHE_CAPACITY, 0);
		queue_request(32'hFFFF_FFFF);
		queue_request(32'h5A5A_A5A5);
		queue_request(32'h0000_0000);
		drive_words();
		drain(8);

		for (int i = 0; i < SLOTS_DEF; i++)
			if (!stim_written[i])
				queue_load(i, $urandom());
		drive_words();
		drain(8);

		for (int c = 0; c < 6; c++) begin
			if (c == 2) begin
				send_idle = 72;
				recv_idle = 35;
			end else if (c == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_reg(REG_CACHE_CAPACITY, cap_plan[c]);
			set_reg(REG_GLYPH_COUNT, gc_plan[c]);
			queue_random(50);
			drive_words();
			drain(8);
		end

		drain(64);
		failures = lfu.mismatches + lfu.expected_words.size();
		$display({"ran %0d input words, checked %0d result words: %0d loads, %0d hits,",
			" %0d fills, %0d evictions, %0d not found"},
			lfu.taken, lfu.checked, lfu.tally[int'(KIND_LOAD)], lfu.tally[int'(KIND_HIT)],
			lfu.tally[int'(KIND_FILL)], lfu.tally[int'(KIND_EVICT)], lfu.tally[int'(KIND_NONE)]);
		$display("longest burst %0d words per input; %0d mismatches, %0d words never seen",
			lfu.burst_max, lfu.mismatches, lfu.expected_words.size());
		if (failures == 0)
			$display("** glyph_cache_lfu_policy: PASSED **");
		else
			$display("** glyph_cache_lfu_policy: FAILED **");
		$finish;
	end
endmodule

/* filelist.f */
hdl/gclfu_pkg.sv
hdl/gclfu_chan_if.sv
hdl/gclfu_ctrl.sv
hdl/gclfu_dp.sv
hdl/glyph_cache_lfu_policy.sv
verif/tb.sv
